FILE: rtl/core/ill_pkg.sv
// Shared types and codes for the indexed linked list engine.
// Holds item structs, command and status codes, and the controller state enum.
// No dependencies.
`default_nettype none

package ill_pkg;

  // Default node store size
  localparam int CAPACITY_DEF = 64;

  // Field widths of the item formats
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 6;
  localparam int LEN_W  = 7;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        [CMD_W-1:0] command;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] new_value;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [FPOS_W-1:0] found_position;
    logic [LEN_W-1:0]  length;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_HOP,
    S_SPLICE,
    S_LINK,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_linked_list_engine.sv
// Top level of the indexed linked list engine: controller, head and count registers.
// Instantiates ill_store; uses ill_pkg.
//
//   channel | direction | handshake           | item
//   req     | in        | req_valid/req_stall | command, position, value, new_value
//   rsp     | out       | rsp_valid/rsp_stall | status, found, found_position, length
//
// One item at a time. Insert at head and rejected inserts need no walk of the list;
// insert at position p > 0 walks the links, one store read per link hop.
// Search and update walk the list from the head and visit at most length nodes.
// Reset empties the list at once; node entries are not cleared.
// req is stalled while an item is in work; a stalled rsp holds the engine in its final state.
`default_nettype none

module indexed_linked_list_engine
  import ill_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req_item,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp_item
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int CNT_W  = LINK_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

  state_t state, state_next;

  // Latched item
  logic [CMD_W-1:0] cmd, cmd_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [VAL_W-1:0] key, key_next;
  logic [VAL_W-1:0] new_val, new_val_next;

  // Walk state
  logic [LINK_W-1:0] cur, cur_next;
  logic [CNT_W-1:0]  hops, hops_next;
  logic [CNT_W-1:0]  scan_pos, scan_pos_next;

  // List state
  logic [LINK_W-1:0] head, head_next;
  logic [CNT_W-1:0]  used, used_next;

  // Pending result
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_found, res_found_next;
  logic [FPOS_W-1:0] res_fpos, res_fpos_next;

  logic      rsp_valid_next;
  rsp_item_t rsp_item_next;

  // Store ports
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wval;
  logic [LINK_W-1:0] wlink;
  logic [ADDR_W-1:0] raddr;
  logic [VAL_W-1:0]  rval;
  logic [LINK_W-1:0] rlink;

  ill_store #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .LINK_W   (LINK_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wval  (wval),
    .wlink (wlink),
    .raddr (raddr),
    .rval  (rval),
    .rlink (rlink)
  );

  assign req_stall = (state != S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_LINK;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      used      <= used_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    pos        <= pos_next;
    key        <= key_next;
    new_val    <= new_val_next;
    cur        <= cur_next;
    hops       <= hops_next;
    scan_pos   <= scan_pos_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_fpos   <= res_fpos_next;
    rsp_item   <= rsp_item_next;
  end

  // Next state, store accesses and result
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    pos_next        = pos;
    key_next        = key;
    new_val_next    = new_val;
    cur_next        = cur;
    hops_next       = hops;
    scan_pos_next   = scan_pos;
    head_next       = head;
    used_next       = used;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_fpos_next   = res_fpos;
    rsp_item_next   = rsp_item;
    rsp_valid_next  = rsp_valid;
    we              = 1'b0;
    waddr           = used[ADDR_W-1:0];
    wval            = key;
    wlink           = NULL_LINK;
    raddr           = cur[ADDR_W-1:0];

    // Drop the result once taken
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next     = req_item.command;
          pos_next     = req_item.position;
          key_next     = req_item.value;
          new_val_next = req_item.new_value;
          state_next   = S_START;
        end
      end

      S_START: begin
        res_status_next = STAT_OK;
        res_found_next  = 1'b0;
        res_fpos_next   = '0;
        case (cmd)
          CMD_INSERT: begin
            if (CMP_W'(pos) > CMP_W'(used)) begin
              res_status_next = STAT_POS_RANGE;
              state_next      = S_DONE;
            end else if (used == FULL_CNT) begin
              res_status_next = STAT_FULL;
              state_next      = S_DONE;
            end else if (pos == '0) begin
              // New head: link to the old head
              we         = 1'b1;
              wlink      = head;
              head_next  = LINK_W'(used);
              used_next  = used + CNT_W'(1);
              state_next = S_DONE;
            end else begin
              // Walk to the node before the insert point
              raddr     = head[ADDR_W-1:0];
              cur_next  = head;
              hops_next = CNT_W'(pos) - CNT_W'(1);
              if (CNT_W'(pos) == CNT_W'(1)) begin
                state_next = S_SPLICE;
              end else begin
                state_next = S_HOP;
              end
            end
          end
          CMD_SEARCH, CMD_UPDATE: begin
            if (used == '0) begin
              res_status_next = STAT_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              raddr         = head[ADDR_W-1:0];
              cur_next      = head;
              scan_pos_next = '0;
              state_next    = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_HOP: begin
        // Follow one link per cycle
        raddr     = rlink[ADDR_W-1:0];
        cur_next  = rlink;
        hops_next = hops - CNT_W'(1);
        if (hops == CNT_W'(1)) begin
          state_next = S_SPLICE;
        end
      end

      S_SPLICE: begin
        if (cur >= NULL_LINK) begin
          // No predecessor node: append a detached node
          we         = 1'b1;
          wlink      = NULL_LINK;
          used_next  = used + CNT_W'(1);
          state_next = S_DONE;
        end else begin
          // Point the predecessor at the fresh slot, keep its old link
          we         = 1'b1;
          waddr      = cur[ADDR_W-1:0];
          wval       = rval;
          wlink      = LINK_W'(used);
          cur_next   = rlink;
          state_next = S_LINK;
        end
      end

      S_LINK: begin
        // Write the fresh node with the predecessor's old link
        we         = 1'b1;
        wlink      = cur;
        used_next  = used + CNT_W'(1);
        state_next = S_DONE;
      end

      S_SCAN: begin
        if (rval == key) begin
          if (cmd == CMD_UPDATE) begin
            we    = 1'b1;
            waddr = cur[ADDR_W-1:0];
            wval  = new_val;
            wlink = rlink;
          end
          res_found_next = 1'b1;
          res_fpos_next  = FPOS_W'(scan_pos);
          state_next     = S_DONE;
        end else if ((scan_pos + CNT_W'(1) == used) || (rlink >= NULL_LINK)) begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          raddr         = rlink[ADDR_W-1:0];
          cur_next      = rlink;
          scan_pos_next = scan_pos + CNT_W'(1);
        end
      end

      S_DONE: begin
        // Hand over once the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next               = 1'b1;
          rsp_item_next.status         = res_status;
          rsp_item_next.found          = res_found;
          rsp_item_next.found_position = res_fpos;
          rsp_item_next.length         = LEN_W'(used);
          state_next                   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/ill_store.sv
// Node store: one value and one next link per slot, one write and one read port.
// Read data is registered. Uses ill_pkg.
`default_nettype none

module ill_store
  import ill_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int LINK_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [VAL_W-1:0]  wval,
  input  wire logic [LINK_W-1:0] wlink,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [VAL_W-1:0]  rval,
  output logic      [LINK_W-1:0] rlink
);

  logic [VAL_W-1:0]  values [CAPACITY];
  logic [LINK_W-1:0] links  [CAPACITY];

  // Write one node
  always_ff @(posedge clk) begin
    if (we) begin
      values[waddr] <= wval;
      links[waddr]  <= wlink;
    end
  end

  // Read one node every cycle
  always_ff @(posedge clk) begin
    rval  <= values[raddr];
    rlink <= links[raddr];
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for indexed_linked_list_engine: directed, back-pressure, random and full-store tests,
// each result checked against a shadow copy of the list kept in this file.
// Depends on ill_pkg and the engine RTL only.
module tb;
  import ill_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               NODES      = CAPACITY_DEF;
  localparam int               IDX_W      = $clog2(NODES);
  localparam logic [POS_W-1:0] NIL        = 7'(CAPACITY_DEF);
  localparam int               CYCLE_LIMIT   = 1_000_000;
  localparam int               SETTLE_CYCLES = 150;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_item  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  indexed_linked_list_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the list: node store, head link and node count
  logic signed [VAL_W-1:0] shadow_val  [NODES];
  logic        [POS_W-1:0] shadow_link [NODES];
  logic        [POS_W-1:0] shadow_head  = NIL;
  int                      shadow_count = 0;

  rsp_item_t awaited_results [$];
  rsp_item_t oldest;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int placed_count  = 0;
  int rejected_count = 0;
  int hit_count     = 0;
  int miss_count    = 0;

  // Apply one operation to the shadow list and return the answer it must give
  function automatic rsp_item_t list_outcome(req_item_t r);
    rsp_item_t        res;
    logic [POS_W-1:0] slot;
    int               pos;
    res = '0;
    res.status = STAT_OK;
    case (r.command)
      CMD_INSERT: begin
        if (r.position > shadow_count) begin
          res.status = STAT_POS_RANGE;
        end else if (shadow_count >= NODES) begin
          res.status = STAT_FULL;
        end else begin
          shadow_val[IDX_W'(shadow_count)] = r.value;
          if (r.position == 0) begin
            shadow_link[IDX_W'(shadow_count)] = shadow_head;
            shadow_head = 7'(shadow_count);
          end else begin
            slot = shadow_head;
            for (pos = 1; pos < r.position; pos++) slot = shadow_link[slot[IDX_W-1:0]];
            shadow_link[IDX_W'(shadow_count)] = shadow_link[slot[IDX_W-1:0]];
            shadow_link[slot[IDX_W-1:0]] = 7'(shadow_count);
          end
          shadow_count++;
        end
      end
      CMD_SEARCH, CMD_UPDATE: begin
        res.status = STAT_NOT_FOUND;
        slot = shadow_head;
        for (pos = 0; pos < shadow_count && res.status == STAT_NOT_FOUND; pos++) begin
          if (shadow_val[slot[IDX_W-1:0]] == r.value) begin
            res.status = STAT_OK;
            res.found = 1'b1;
            res.found_position = 6'(pos);
            if (r.command == CMD_UPDATE) shadow_val[slot[IDX_W-1:0]] = r.new_value;
          end else begin
            slot = shadow_link[slot[IDX_W-1:0]];
          end
        end
      end
      default: ;
    endcase
    res.length = 7'(shadow_count);
    return res;
  endfunction

  function automatic req_item_t make_req(logic [CMD_W-1:0] cmd, int pos,
                                         logic [VAL_W-1:0] val, logic [VAL_W-1:0] nval);
    req_item_t r;
    r.command   = cmd;
    r.position  = 7'(pos);
    r.value     = val;
    r.new_value = nval;
    return r;
  endfunction

  // Favor a small pool and the extremes so duplicates and hits are common
  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly lookups of present keys, some inserts, a few stray commands
  function automatic req_item_t random_request();
    req_item_t r;
    int        pick;
    r.value     = random_word();
    r.new_value = random_word();
    r.position  = 7'($urandom);
    pick = $urandom_range(99);
    if (pick < 9) begin
      r.command = CMD_INSERT;
      pick = $urandom_range(99);
      if (pick < 85) r.position = 7'($urandom_range(shadow_count, 0));
      else if (pick < 93) r.position = pick[0] ? 7'd0 : 7'(shadow_count);
      else r.position = 7'($urandom_range(127, shadow_count + 1));
    end else if (pick < 97) begin
      r.command = (pick < 60) ? CMD_SEARCH : CMD_UPDATE;
      if (shadow_count > 0 && $urandom_range(99) < 65)
        r.value = shadow_val[IDX_W'($urandom_range(shadow_count - 1))];
    end else begin
      r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  // Offer one item, hold it until taken, then record what it must produce
  task automatic send_item(req_item_t item);
    rsp_item_t res;
    bit        taken;
    int        gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !req_stall;
    end
    res = list_outcome(item);
    awaited_results.push_back(res);
    items_sent++;
    if (item.command == CMD_INSERT) begin
      if (res.status == STAT_OK) placed_count++;
      else rejected_count++;
    end else if (item.command != CMD_UNUSED) begin
      if (res.found) hit_count++;
      else miss_count++;
    end
  endtask

  // Stop offering and wait for every awaited result
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Receiver: long hold-off when asked, random stall otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each taken result with the oldest awaited one
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, length", int'(rsp_item.length), 0);
      end else begin
        oldest = awaited_results.pop_front();
        if (rsp_item.status !== oldest.status)
          report_mismatch("status", int'(rsp_item.status), int'(oldest.status));
        if (rsp_item.found !== oldest.found)
          report_mismatch("found", int'(rsp_item.found), int'(oldest.found));
        if (rsp_item.found_position !== oldest.found_position)
          report_mismatch("found_position", int'(rsp_item.found_position),
                          int'(oldest.found_position));
        if (rsp_item.length !== oldest.length)
          report_mismatch("length", int'(rsp_item.length), int'(oldest.length));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Empty list, range rejects, head/middle/tail inserts, first-match rules, stray command
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(make_req(CMD_SEARCH, 0, 32'd5, 32'd0));
    send_item(make_req(CMD_UPDATE, 0, 32'd5, 32'd6));
    send_item(make_req(CMD_INSERT, 1, 32'd9, 32'd0));
    send_item(make_req(CMD_INSERT, 127, 32'd9, 32'hffff_ffff));
    send_item(make_req(CMD_INSERT, 0, 32'h8000_0000, 32'd0));
    send_item(make_req(CMD_INSERT, 1, 32'h7fff_ffff, 32'd0));
    send_item(make_req(CMD_INSERT, 1, 32'd0, 32'd0));
    send_item(make_req(CMD_INSERT, 0, 32'hffff_ffff, 32'd0));
    send_item(make_req(CMD_INSERT, 4, 32'd5, 32'd0));
    send_item(make_req(CMD_INSERT, 6, 32'd7, 32'd0));
    send_item(make_req(CMD_SEARCH, 0, 32'h7fff_ffff, 32'd0));
    send_item(make_req(CMD_SEARCH, 0, 32'hffff_ffff, 32'd0));
    send_item(make_req(CMD_SEARCH, 0, 32'd5, 32'd0));
    send_item(make_req(CMD_SEARCH, 0, 32'd12345, 32'd0));
    send_item(make_req(CMD_UPDATE, 0, 32'd0, 32'h7fff_ffff));
    send_item(make_req(CMD_SEARCH, 0, 32'h7fff_ffff, 32'd0));
    send_item(make_req(CMD_UPDATE, 0, 32'd99, 32'd1));
    send_item(make_req(CMD_UPDATE, 0, 32'h7fff_ffff, 32'hffff_fffe));
    send_item(make_req(CMD_SEARCH, 0, 32'h7fff_ffff, 32'd0));
    send_item(make_req(CMD_UNUSED, 127, 32'hffff_ffff, 32'hffff_ffff));
    send_item(make_req(CMD_INSERT, 2, 32'h5555_5555, 32'haaaa_aaaa));
    send_item(make_req(CMD_SEARCH, 0, 32'h5555_5555, 32'd0));
    drain_results();
  endtask

  // Hold the receiver off while items keep coming, then let it all drain
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 400;
    repeat (8) send_item(random_request());
    drain_results();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_item(random_request());
    drain_results();
  endtask

  // Fill the store, then check full and range rejects and walks over a full list
  task automatic test_full_store();
    send_idle_pct = 22;
    recv_idle_pct = 22;
    while (shadow_count < NODES)
      send_item(make_req(CMD_INSERT, $urandom_range(shadow_count, 0),
                         random_word(), random_word()));
    send_item(make_req(CMD_INSERT, 0, 32'd1, 32'd0));
    send_item(make_req(CMD_INSERT, NODES, 32'd1, 32'd0));
    send_item(make_req(CMD_INSERT, NODES + 1, 32'd1, 32'd0));
    send_item(make_req(CMD_SEARCH, 127, 32'hdead_beef, 32'd0));
    repeat (6) send_item(random_request());
    drain_results();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(605, 22, 51);
    test_random(605, 51, 22);
    test_random(605, 0, 0);
    test_full_store();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 0, awaited_results.size());
    $display("covered %0d items: %0d inserts placed, %0d inserts rejected",
             items_sent, placed_count, rejected_count);
    $display("lookups: %0d hit, %0d missed; final length %0d",
             hit_count, miss_count, shadow_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ill_pkg.sv
rtl/core/ill_store.sv
rtl/core/indexed_linked_list_engine.sv
dv/tb.sv
